// File: sv/frc_pkg.sv
package frc_pkg;

  // Default frame store capacity in bytes (1 to 64)
  localparam int unsigned FRAME_CAP_DEFAULT = 64;

  // Field widths fixed by the interface
  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned LEN_IN_W = 8;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned ST_W    = 3;
  localparam int unsigned PH_W    = 2;

  // Silence count after reset
  localparam logic [CNT_W-1:0] SILENCE_RESET = 16'd2;

  // Input function codes
  localparam logic [FUNC_W-1:0] FN_TICK  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_ARM   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_WRITE = 3'd2;
  localparam logic [FUNC_W-1:0] FN_CLEAR = 3'd3;
  localparam logic [FUNC_W-1:0] FN_SENT  = 3'd4;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK      = 3'd0;
  localparam logic [ST_W-1:0] ST_BUSY    = 3'd1;
  localparam logic [ST_W-1:0] ST_LONG    = 3'd2;
  localparam logic [ST_W-1:0] ST_GAVE_UP = 3'd3;
  localparam logic [ST_W-1:0] ST_EMPTY   = 3'd4;

  // Transmit phase codes
  localparam logic [PH_W-1:0] PH_IDLE  = 2'd0;
  localparam logic [PH_W-1:0] PH_READY = 2'd1;
  localparam logic [PH_W-1:0] PH_WAIT  = 2'd2;

  // Result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_BYTE   = 1'b1;

  // Commands from controller to datapath
  typedef struct packed {
    logic            arm;        // load frame parameters, go ready
    logic            wr_byte;    // write one store byte
    logic            clear;      // back to idle, counters zeroed
    logic            sil_reload; // reload silence count
    logic            sil_dec;    // count silence down
    logic            start_send; // go waiting, reload silence, rewind pointer
    logic            ack_inc;    // count acknowledge wait up
    logic            retry;      // count a resend, go ready
    logic            out_status; // load a status word into the output register
    logic            out_byte;   // load the next frame byte into the output register
    logic [ST_W-1:0] st;         // status code for out_status
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [PH_W-1:0] phase;
    logic            sil_zero;   // silence count is zero
    logic            ack_cont;   // wait not over after this tick
    logic            retry_stop; // no resend left
    logic            len_zero;   // armed frame is empty
    logic            len_ok;     // arm length fits the store
    logic            idx_ok;     // write index inside the store
    logic            ptr_last;   // byte in flight is the final one
    logic            out_busy;   // output register holds a word not taken this cycle
  } sts_t;

endpackage

// File: sv/frame_retransmit_controller.sv
// Stop-and-wait transmitter with retry.
// Input channel (in_valid_i/in_ready_o) takes one command word: tick, arm,
// frame byte write, clear (acknowledge) or direct send done. Each word gives
// one status word on the output channel (out_valid_o/out_ready_i), except a
// tick that starts a nonempty send: it gives frame_len byte words from the
// frame store, the final one marked by last_o.
// Config channel (cfg_valid_i/cfg_ready_o) writes silence_ticks; always ready.
// A status word appears in the cycle after its command is accepted. One
// command per cycle is taken while idle with the output register free; a
// send holds off commands until its final byte is loaded, paced by
// the single read port of the frame store (registered, one address a cycle).
// Reset: idle, counters zero, silence_ticks and its count set to 2; the
// frame store holds no defined contents until written.
// Receiver stall: the output register holds its word; the input channel and
// the byte sequencer wait until that word is taken, and no word is lost.
module frame_retransmit_controller #(
  parameter int unsigned FRAME_CAP = frc_pkg::FRAME_CAP_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [frc_pkg::CNT_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [frc_pkg::FUNC_W-1:0]    func_i,
  input  logic [frc_pkg::LEN_IN_W-1:0]  frame_length_i,
  input  logic [frc_pkg::CNT_W-1:0]     retry_limit_i,
  input  logic [frc_pkg::CNT_W-1:0]     ack_wait_i,
  input  logic [frc_pkg::IDX_W-1:0]     byte_index_i,
  input  logic [frc_pkg::BYTE_W-1:0]    frame_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          out_kind_o,
  output logic [frc_pkg::ST_W-1:0]      status_o,
  output logic [frc_pkg::BYTE_W-1:0]    tx_byte_o,
  output logic                          last_o,
  output logic [frc_pkg::PH_W-1:0]      tx_state_o,
  output logic [frc_pkg::CNT_W-1:0]     retries_done_o
);

  frc_pkg::cmd_t cmd;
  frc_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  frc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  frc_datapath #(
    .FRAME_CAP (FRAME_CAP)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .frame_length_i (frame_length_i),
    .retry_limit_i  (retry_limit_i),
    .ack_wait_i     (ack_wait_i),
    .byte_index_i   (byte_index_i),
    .frame_byte_i   (frame_byte_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .out_kind_o     (out_kind_o),
    .status_o       (status_o),
    .tx_byte_o      (tx_byte_o),
    .last_o         (last_o),
    .tx_state_o     (tx_state_o),
    .retries_done_o (retries_done_o),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

endmodule

// File: sv/frc_ctrl.sv
module frc_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [frc_pkg::FUNC_W-1:0]  func_i,
  input  frc_pkg::sts_t               sts_i,
  output frc_pkg::cmd_t               cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SEND = 2'b10
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        accept;

  assign in_ready_o = (state_q == S_IDLE) && !sts_i.out_busy;
  assign accept     = in_valid_i && in_ready_o;

  // Decode of accepted words and byte sequencing
  always_comb begin
    cmd_o   = '0;
    cmd_o.st = frc_pkg::ST_OK;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.out_status = 1'b1;
          case (func_i)
            frc_pkg::FN_TICK: begin
              if (sts_i.phase == frc_pkg::PH_IDLE) begin
                cmd_o.st = frc_pkg::ST_OK;
              end else if (!sts_i.sil_zero) begin
                cmd_o.sil_dec = 1'b1;
              end else if (sts_i.phase == frc_pkg::PH_READY) begin
                cmd_o.start_send = 1'b1;
                if (sts_i.len_zero) begin
                  cmd_o.st = frc_pkg::ST_EMPTY;
                end else begin
                  // bytes follow from the store instead of a status word
                  cmd_o.out_status = 1'b0;
                  state_d = S_SEND;
                end
              end else if (sts_i.ack_cont) begin
                cmd_o.ack_inc = 1'b1;
              end else if (sts_i.retry_stop) begin
                cmd_o.clear = 1'b1;
                cmd_o.st    = frc_pkg::ST_GAVE_UP;
              end else begin
                cmd_o.retry = 1'b1;
              end
            end
            frc_pkg::FN_ARM: begin
              if (sts_i.phase != frc_pkg::PH_IDLE) begin
                cmd_o.st = frc_pkg::ST_BUSY;
              end else if (!sts_i.len_ok) begin
                cmd_o.st = frc_pkg::ST_LONG;
              end else begin
                cmd_o.arm = 1'b1;
              end
            end
            frc_pkg::FN_WRITE: begin
              if (sts_i.phase != frc_pkg::PH_IDLE) begin
                cmd_o.st = frc_pkg::ST_BUSY;
              end else if (!sts_i.idx_ok) begin
                cmd_o.st = frc_pkg::ST_LONG;
              end else begin
                cmd_o.wr_byte = 1'b1;
              end
            end
            frc_pkg::FN_CLEAR: begin
              cmd_o.clear = 1'b1;
            end
            frc_pkg::FN_SENT: begin
              cmd_o.sil_reload = 1'b1;
            end
            default: begin
              cmd_o.st = frc_pkg::ST_OK;
            end
          endcase
        end
      end
      S_SEND: begin
        // one byte per cycle while the output register has room
        if (!sts_i.out_busy) begin
          cmd_o.out_byte = 1'b1;
          if (sts_i.ptr_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: sv/frc_datapath.sv
module frc_datapath #(
  parameter int unsigned FRAME_CAP = frc_pkg::FRAME_CAP_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_valid_i,
  input  logic [frc_pkg::CNT_W-1:0]     cfg_data_i,
  // input word fields
  input  logic [frc_pkg::LEN_IN_W-1:0]  frame_length_i,
  input  logic [frc_pkg::CNT_W-1:0]     retry_limit_i,
  input  logic [frc_pkg::CNT_W-1:0]     ack_wait_i,
  input  logic [frc_pkg::IDX_W-1:0]     byte_index_i,
  input  logic [frc_pkg::BYTE_W-1:0]    frame_byte_i,
  // output register
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic                          out_kind_o,
  output logic [frc_pkg::ST_W-1:0]      status_o,
  output logic [frc_pkg::BYTE_W-1:0]    tx_byte_o,
  output logic                          last_o,
  output logic [frc_pkg::PH_W-1:0]      tx_state_o,
  output logic [frc_pkg::CNT_W-1:0]     retries_done_o,
  // controller link
  input  frc_pkg::cmd_t                 cmd_i,
  output frc_pkg::sts_t                 sts_o
);

  localparam int unsigned AW    = (FRAME_CAP > 1) ? $clog2(FRAME_CAP) : 1;
  localparam int unsigned LEN_W = $clog2(FRAME_CAP + 1);
  localparam int unsigned CW    = frc_pkg::CNT_W;

  // Frame store
  logic [frc_pkg::BYTE_W-1:0] mem [FRAME_CAP];
  logic [frc_pkg::BYTE_W-1:0] rdata_q;

  // Link state
  logic [CW-1:0]          silence_ticks_q;
  logic [CW-1:0]          sil_q, sil_d;
  logic [CW-1:0]          ack_q, ack_d;
  logic [CW-1:0]          retry_q, retry_d;
  logic [CW-1:0]          retry_max_q, retry_max_d;
  logic [CW-1:0]          ack_limit_q, ack_limit_d;
  logic [LEN_W-1:0]       len_q, len_d;
  logic [frc_pkg::PH_W-1:0] phase_q, phase_d;
  logic [LEN_W-1:0]       ptr_q, ptr_d;
  logic [CW:0]            ack_inc;

  // Output register
  logic                          out_valid_q;
  logic                          kind_q;
  logic [frc_pkg::ST_W-1:0]      st_q;
  logic [frc_pkg::BYTE_W-1:0]    byte_q;
  logic                          last_q;
  logic [frc_pkg::PH_W-1:0]      txst_q;
  logic [CW-1:0]                 rdone_q;

  assign ack_inc = {1'b0, ack_q} + {{CW{1'b0}}, 1'b1};

  // Status toward the controller
  always_comb begin
    sts_o.phase      = phase_q;
    sts_o.sil_zero   = (sil_q == '0);
    sts_o.ack_cont   = ack_inc < {1'b0, ack_limit_q};
    sts_o.retry_stop = (retry_max_q == '0) || (retry_q >= retry_max_q);
    sts_o.len_zero   = (len_q == '0);
    sts_o.len_ok     = frame_length_i <= frc_pkg::LEN_IN_W'(FRAME_CAP);
    sts_o.idx_ok     = {1'b0, byte_index_i} < (frc_pkg::IDX_W + 1)'(FRAME_CAP);
    sts_o.ptr_last   = ({1'b0, ptr_q} + (LEN_W + 1)'(1)) == {1'b0, len_q};
    sts_o.out_busy   = out_valid_q && !out_ready_i;
  end

  // Next state of the link
  always_comb begin
    phase_d     = phase_q;
    retry_d     = retry_q;
    ack_d       = ack_q;
    retry_max_d = retry_max_q;
    ack_limit_d = ack_limit_q;
    len_d       = len_q;
    sil_d       = sil_q;
    ptr_d       = ptr_q;
    if (cmd_i.arm) begin
      phase_d     = frc_pkg::PH_READY;
      retry_d     = '0;
      ack_d       = '0;
      retry_max_d = retry_limit_i;
      ack_limit_d = ack_wait_i;
      len_d       = frame_length_i[LEN_W-1:0];
    end
    if (cmd_i.clear) begin
      phase_d     = frc_pkg::PH_IDLE;
      retry_d     = '0;
      ack_d       = '0;
      retry_max_d = '0;
      ack_limit_d = '0;
      len_d       = '0;
    end
    if (cmd_i.retry) begin
      phase_d = frc_pkg::PH_READY;
      retry_d = retry_q + CW'(1);
      ack_d   = '0;
    end
    if (cmd_i.ack_inc) begin
      ack_d = ack_inc[CW-1:0];
    end
    if (cmd_i.sil_dec) begin
      sil_d = sil_q - CW'(1);
    end
    if (cmd_i.sil_reload || cmd_i.start_send) begin
      sil_d = silence_ticks_q;
    end
    if (cmd_i.start_send) begin
      phase_d = frc_pkg::PH_WAIT;
      ptr_d   = '0;
    end
    if (cmd_i.out_byte) begin
      ptr_d = ptr_q + LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      silence_ticks_q <= frc_pkg::SILENCE_RESET;
      sil_q           <= frc_pkg::SILENCE_RESET;
      ack_q           <= '0;
      retry_q         <= '0;
      retry_max_q     <= '0;
      ack_limit_q     <= '0;
      len_q           <= '0;
      phase_q         <= frc_pkg::PH_IDLE;
      ptr_q           <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        silence_ticks_q <= cfg_data_i;
      end
      sil_q       <= sil_d;
      ack_q       <= ack_d;
      retry_q     <= retry_d;
      retry_max_q <= retry_max_d;
      ack_limit_q <= ack_limit_d;
      len_q       <= len_d;
      phase_q     <= phase_d;
      ptr_q       <= ptr_d;
      if (cmd_i.out_status || cmd_i.out_byte) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Store write and registered read of the next byte to send
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_byte) begin
      mem[byte_index_i[AW-1:0]] <= frame_byte_i;
    end
    rdata_q <= mem[ptr_d[AW-1:0]];
  end

  // Output word payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_status) begin
      kind_q  <= frc_pkg::KIND_STATUS;
      st_q    <= cmd_i.st;
      byte_q  <= '0;
      last_q  <= 1'b1;
      txst_q  <= phase_d;
      rdone_q <= retry_d;
    end else if (cmd_i.out_byte) begin
      kind_q  <= frc_pkg::KIND_BYTE;
      st_q    <= frc_pkg::ST_OK;
      byte_q  <= rdata_q;
      last_q  <= sts_o.ptr_last;
      txst_q  <= phase_q;
      rdone_q <= retry_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_kind_o     = kind_q;
  assign status_o       = st_q;
  assign tx_byte_o      = byte_q;
  assign last_o         = last_q;
  assign tx_state_o     = txst_q;
  assign retries_done_o = rdone_q;

endmodule

// File: sv/frc_checker.sv
module frc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic                          out_kind_o,
  input logic [frc_pkg::ST_W-1:0]      status_o,
  input logic [frc_pkg::BYTE_W-1:0]    tx_byte_o,
  input logic                          last_o,
  input logic [frc_pkg::PH_W-1:0]      tx_state_o,
  input logic [frc_pkg::CNT_W-1:0]     retries_done_o
);

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(tx_byte_o) &&
      $stable(status_o) && $stable(last_o) && $stable(out_kind_o))
    else $error("output word changed while stalled");

  // Frame bytes go out only while waiting for the acknowledge, with ok status
  a_byte_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_kind_o == frc_pkg::KIND_BYTE) |->
      (status_o == frc_pkg::ST_OK) && (tx_state_o == frc_pkg::PH_WAIT))
    else $error("byte word outside acknowledge wait");

  // A status word is a single word with a zero byte field
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_kind_o == frc_pkg::KIND_STATUS) |->
      last_o && (tx_byte_o == '0))
    else $error("status word not marked last or byte not zero");

  // Giving up leaves the block idle with its resend count cleared
  a_gave_up_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_kind_o == frc_pkg::KIND_STATUS) &&
      (status_o == frc_pkg::ST_GAVE_UP) |->
      (tx_state_o == frc_pkg::PH_IDLE) && (retries_done_o == '0))
    else $error("gave up without returning to idle");

endmodule

bind frame_retransmit_controller frc_checker u_frc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .out_kind_o     (out_kind_o),
  .status_o       (status_o),
  .tx_byte_o      (tx_byte_o),
  .last_o         (last_o),
  .tx_state_o     (tx_state_o),
  .retries_done_o (retries_done_o)
);
